### rtl/core/assert_macros.svh
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/bba_pkg.sv
// shared types and constants of the block bitmap allocator
`default_nettype none

package bba_pkg;

   // fixed field widths
   localparam int ACT_W   = 2;
   localparam int START_W = 12;
   localparam int LEN_W   = 13;
   localparam int STAT_W  = 2;
   localparam int FOUND_W = 12;
   localparam int WORD_W  = 8;

   // request actions
   typedef enum logic [ACT_W-1:0] {
      ACT_TAKE      = 2'd0,
      ACT_FREE      = 2'd1,
      ACT_FIND      = 2'd2,
      ACT_FIND_TAKE = 2'd3
   } action_type;

   // response status codes
   localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE   = 2'd1;
   localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd2;

   // control of the map word unit
   typedef struct packed {
      logic search;
      logic taken;
   } wu_ctrl_type;

endpackage

`default_nettype wire

### rtl/core/bba_if.sv
// request and response channel interfaces of the block bitmap allocator
`default_nettype none

interface bba_req_if;
   logic                         valid;
   logic                         ready;
   logic [bba_pkg::ACT_W-1:0]    action;
   logic [bba_pkg::START_W-1:0]  start_block;
   logic [bba_pkg::LEN_W-1:0]    length;

   modport source (output valid, output action, output start_block, output length,
                   input ready);
   modport sink   (input valid, input action, input start_block, input length,
                   output ready);
endinterface

interface bba_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bba_pkg::STAT_W-1:0]   status;
   logic [bba_pkg::FOUND_W-1:0]  found_block;

   modport source (output valid, output status, output found_block, input ready);
   modport sink   (input valid, input status, input found_block, output ready);
endinterface

`default_nettype wire

### rtl/core/bba_word_unit.sv
// map word unit: first-fit scan step or range mask update over one 8-bit map word
`default_nettype none

module bba_word_unit #(
   parameter int BLOCK_COUNT = 4096,
   parameter int IDX_W       = 21
) (
   input  bba_pkg::wu_ctrl_type          ctrl,
   input  logic [bba_pkg::WORD_W-1:0]    word_in,
   input  logic [IDX_W-1:0]              base,
   input  logic [IDX_W-1:0]              lo,
   input  logic [IDX_W-1:0]              hi,
   input  logic [IDX_W-1:0]              len,
   input  logic [IDX_W-1:0]              count_in,
   input  logic [IDX_W-1:0]              run_in,
   output logic [bba_pkg::WORD_W-1:0]    word_out,
   output logic [IDX_W-1:0]              count_out,
   output logic [IDX_W-1:0]              run_out,
   output logic                          hit,
   output logic [IDX_W-1:0]              where
);

   localparam logic [IDX_W-1:0] LIMIT = IDX_W'(BLOCK_COUNT);

   // eight bit steps, run count carried from the previous word
   always_comb begin
      logic [IDX_W-1:0] blk;
      logic             free;
      word_out  = word_in;
      count_out = count_in;
      run_out   = run_in;
      hit       = 1'b0;
      where     = '0;
      for (int i = 0; i < bba_pkg::WORD_W; i++) begin
         blk  = base + IDX_W'(i);
         free = !word_in[i] && (blk < LIMIT);
         if (ctrl.search) begin
            if (!hit) begin
               if (!free) begin
                  count_out = '0;
               end else begin
                  if (count_out == '0) begin
                     run_out = blk;
                  end
                  count_out = count_out + IDX_W'(1);
                  if (count_out >= len) begin
                     hit   = 1'b1;
                     where = run_out;
                  end
               end
            end
         end else if (blk >= lo && blk <= hi) begin
            word_out[i] = ctrl.taken;
         end
      end
   end

endmodule

`default_nettype wire

### rtl/core/block_bitmap_allocator_core.sv
// Block bitmap allocator: one free/taken bit per storage block kept in an on-chip map memory
// of (BLOCK_COUNT+7)/8 bytes, walked one byte per cycle by a single word unit under a small
// sequencer. After reset a clearing pass writes zero to every map byte, during which no
// request is taken. One request is worked on at a time: a refused request (zero length,
// range past the end, run longer than the device) goes straight to the response; marking
// a range reads and rewrites each map byte it spans; a search reads the bytes from the
// first up to the one where the run completes, at most (BLOCK_COUNT+7)/8 of them;
// find-and-take adds a setup state and the marking of the run. The map memory has a
// single read port, read once per byte. The response sits in an output register, so the
// next request is taken while a response waits.
`default_nettype none

module block_bitmap_allocator_core #(
   parameter int BLOCK_COUNT = 4096
) (
   input  logic          clock,
   input  logic          reset,
   bba_req_if.sink       req_port,
   bba_rsp_if.source     rsp_port
);

   localparam int WORDS  = (BLOCK_COUNT + 7) / 8;
   localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CNT_W  = $clog2(BLOCK_COUNT + 1);
   localparam int W0     = (CNT_W > bba_pkg::LEN_W) ? CNT_W : bba_pkg::LEN_W;
   localparam int IDX_W  = ((W0 > ADDR_W + 3) ? W0 : ADDR_W + 3) + 1;
   localparam logic [ADDR_W-1:0] WORD_LAST = ADDR_W'(WORDS - 1);
   localparam logic [IDX_W-1:0]  LIMIT     = IDX_W'(BLOCK_COUNT);

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_SEARCH = 6'b000100,
      S_SETUP  = 6'b001000,
      S_MARK   = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   state_type                     state_ff, state_in;
   bba_pkg::action_type           act_ff, act_in;
   logic [IDX_W-1:0]              len_ff, len_in;
   logic [IDX_W-1:0]              lo_ff, lo_in;
   logic [IDX_W-1:0]              hi_ff, hi_in;
   logic [IDX_W-1:0]              count_ff, count_in;
   logic [IDX_W-1:0]              run_ff, run_in;
   logic [ADDR_W-1:0]             ptr_ff, ptr_in;
   logic [ADDR_W-1:0]             last_ff, last_in;
   logic [ADDR_W-1:0]             proc_addr_ff, proc_addr_in;
   logic                          reading_ff, reading_in;
   logic                          proc_vld_ff, proc_vld_in;
   logic [bba_pkg::STAT_W-1:0]    res_status_ff, res_status_in;
   logic [IDX_W-1:0]              res_found_ff, res_found_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bba_pkg::STAT_W-1:0]    rsp_status_ff;
   logic [bba_pkg::FOUND_W-1:0]   rsp_found_ff;
   logic [bba_pkg::WORD_W-1:0]    rdata_ff;
   logic                          rsp_load;

   logic [bba_pkg::WORD_W-1:0]    map_mem [WORDS];
   logic                          mem_we;
   logic [ADDR_W-1:0]             mem_waddr;
   logic [bba_pkg::WORD_W-1:0]    mem_wdata;

   bba_pkg::wu_ctrl_type          wu_ctrl;
   logic [bba_pkg::WORD_W-1:0]    wu_word;
   logic [IDX_W-1:0]              wu_count;
   logic [IDX_W-1:0]              wu_run;
   logic                          wu_hit;
   logic [IDX_W-1:0]              wu_where;
   logic [IDX_W-1:0]              wu_base;

   logic                          req_accept;
   bba_pkg::action_type           req_act;
   logic [IDX_W-1:0]              start_w;
   logic [IDX_W-1:0]              len_w;
   logic [IDX_W-1:0]              end_w;
   logic [IDX_W-1:0]              mark_hi;
   logic [IDX_W-1:0]              take_hi;

   // request decode
   assign req_port.ready = (state_ff == S_IDLE);
   assign req_accept     = req_port.valid && req_port.ready;
   assign req_act        = bba_pkg::action_type'(req_port.action);
   assign start_w        = IDX_W'(req_port.start_block);
   assign len_w          = IDX_W'(req_port.length);
   assign end_w          = start_w + len_w;
   assign mark_hi        = end_w - IDX_W'(1);
   assign take_hi        = lo_ff + len_ff - IDX_W'(1);

   // word unit hookup
   assign wu_ctrl.search = (state_ff == S_SEARCH);
   assign wu_ctrl.taken  = (act_ff != bba_pkg::ACT_FREE);
   assign wu_base        = IDX_W'({proc_addr_ff, 3'b000});

   bba_word_unit #(
      .BLOCK_COUNT (BLOCK_COUNT),
      .IDX_W       (IDX_W)
   ) u_word_unit (
      .ctrl      (wu_ctrl),
      .word_in   (rdata_ff),
      .base      (wu_base),
      .lo        (lo_ff),
      .hi        (hi_ff),
      .len       (len_ff),
      .count_in  (count_ff),
      .run_in    (run_ff),
      .word_out  (wu_word),
      .count_out (wu_count),
      .run_out   (wu_run),
      .hit       (wu_hit),
      .where     (wu_where)
   );

   // map write port: clearing pass or range update
   assign mem_we    = (state_ff == S_CLEAR) || ((state_ff == S_MARK) && proc_vld_ff);
   assign mem_waddr = (state_ff == S_CLEAR) ? ptr_ff : proc_addr_ff;
   assign mem_wdata = (state_ff == S_CLEAR) ? '0 : wu_word;

   // map memory with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      if (reading_ff) begin
         rdata_ff <= map_mem[ptr_ff];
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      len_in        = len_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      count_in      = count_ff;
      run_in        = run_ff;
      ptr_in        = ptr_ff;
      last_in       = last_ff;
      proc_addr_in  = proc_addr_ff;
      reading_in    = reading_ff;
      proc_vld_in   = 1'b0;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      rsp_load      = 1'b0;

      // read stream shared by search and mark
      if ((state_ff == S_SEARCH) || (state_ff == S_MARK)) begin
         if (reading_ff) begin
            proc_vld_in  = 1'b1;
            proc_addr_in = ptr_ff;
            if (ptr_ff == last_ff) begin
               reading_in = 1'b0;
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end
      end

      unique case (state_ff)
         S_CLEAR: begin
            if (ptr_ff == WORD_LAST) begin
               state_in = S_IDLE;
            end else begin
               ptr_in = ptr_ff + ADDR_W'(1);
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               act_in        = req_act;
               len_in        = len_w;
               count_in      = '0;
               run_in        = '0;
               res_status_in = bba_pkg::ST_DONE;
               res_found_in  = '0;
               if (len_w == '0) begin
                  res_status_in = bba_pkg::ST_RANGE;
                  state_in      = S_FINISH;
               end else begin
                  case (req_act) inside
                     bba_pkg::ACT_TAKE, bba_pkg::ACT_FREE: begin
                        if (end_w > LIMIT) begin
                           res_status_in = bba_pkg::ST_RANGE;
                           state_in      = S_FINISH;
                        end else begin
                           lo_in      = start_w;
                           hi_in      = mark_hi;
                           ptr_in     = start_w[ADDR_W+2:3];
                           last_in    = mark_hi[ADDR_W+2:3];
                           reading_in = 1'b1;
                           state_in   = S_MARK;
                        end
                     end
                     default: begin
                        if (len_w > LIMIT) begin
                           res_status_in = bba_pkg::ST_NOSPACE;
                           state_in      = S_FINISH;
                        end else begin
                           ptr_in     = '0;
                           last_in    = WORD_LAST;
                           reading_in = 1'b1;
                           state_in   = S_SEARCH;
                        end
                     end
                  endcase
               end
            end
         end
         S_SEARCH: begin
            if (proc_vld_ff) begin
               count_in = wu_count;
               run_in   = wu_run;
               if (wu_hit) begin
                  res_found_in = wu_where;
                  reading_in   = 1'b0;
                  proc_vld_in  = 1'b0;
                  if (act_ff == bba_pkg::ACT_FIND_TAKE) begin
                     lo_in    = wu_where;
                     state_in = S_SETUP;
                  end else begin
                     state_in = S_FINISH;
                  end
               end else if (proc_addr_ff == last_ff) begin
                  res_status_in = bba_pkg::ST_NOSPACE;
                  state_in      = S_FINISH;
               end
            end
         end
         S_SETUP: begin
            hi_in      = take_hi;
            ptr_in     = lo_ff[ADDR_W+2:3];
            last_in    = take_hi[ADDR_W+2:3];
            reading_in = 1'b1;
            state_in   = S_MARK;
         end
         S_MARK: begin
            if (proc_vld_ff && (proc_addr_ff == last_ff)) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response register handshake
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         ptr_ff       <= '0;
         reading_ff   <= 1'b0;
         proc_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         reading_ff   <= reading_in;
         proc_vld_ff  <= proc_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      len_ff        <= len_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      count_ff      <= count_in;
      run_ff        <= run_in;
      last_ff       <= last_in;
      proc_addr_ff  <= proc_addr_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_found_ff  <= res_found_ff[bba_pkg::FOUND_W-1:0];
      end
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.status      = rsp_status_ff;
   assign rsp_port.found_block = rsp_found_ff;

endmodule

`default_nettype wire

### rtl/core/bba_checker.sv
// port-level checker for the block bitmap allocator, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module bba_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [bba_pkg::STAT_W-1:0]   rsp_status,
   input wire logic [bba_pkg::FOUND_W-1:0]  rsp_found_block
);

   // one request at a time: busy right after a request is taken
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready right after accept")

   // no response can come out of the cycle a request is taken
   `ASSERT_NEXT(a_no_early_rsp, clock, reset, req_valid && req_ready && !rsp_valid, !rsp_valid, "response too early")

   // found block is only reported with a done status
   `ASSERT_IMPL(a_found_zero, clock, reset, rsp_valid && (rsp_status != bba_pkg::ST_DONE), rsp_found_block == '0, "found block set on failure")

   // stalled response holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_found_block), "response changed while stalled")

endmodule

bind block_bitmap_allocator_core bba_checker u_bba_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_port.valid),
   .req_ready       (req_port.ready),
   .rsp_valid       (rsp_port.valid),
   .rsp_ready       (rsp_port.ready),
   .rsp_status      (rsp_port.status),
   .rsp_found_block (rsp_port.found_block)
);

`default_nettype wire
